### rtl/core/tadr_pkg.sv
package tadr_pkg;

    localparam int STATE_WIDTH_DEF    = 32;
    localparam int QUAT_FRAC_BITS_DEF = 14;

    localparam int CMD_W     = 2;
    localparam int QUAT_W    = 16;
    localparam int THRUST_W  = 16;
    localparam int COL_W     = 16;
    localparam int GRAV_W    = 22;
    localparam int INVM_W    = 24;
    localparam int DT_W      = 24;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int OUT_W     = 32;
    localparam int OUT_ITEMS = 6;
    localparam int S_DATA_W  = 4 * QUAT_W + THRUST_W;
    localparam int M_DATA_W  = OUT_ITEMS * OUT_W;

    localparam logic [CMD_W-1:0] CMD_ORIENT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_THRUST = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_MASS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_DOWN = 2'd3;

    localparam logic [GRAV_W-1:0]       GRAVITY_RESET      = 22'd642253;
    localparam logic [INVM_W-1:0]       INVERSE_MASS_RESET = 24'd41801;
    localparam logic [DT_W-1:0]         TIME_STEP_RESET    = 24'd167772;
    localparam logic signed [CFG_W-1:0] INITIAL_DOWN_RESET = -32'sd5243;

    localparam int AXES         = 3;
    localparam int AXIS_W       = 2;
    localparam int STEP_W       = 4;
    localparam int ORIENT_STEPS = 3;
    localparam int TICK_STEPS   = 9;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_QMUL,
        OP_QMUL2,
        OP_COL_SET,
        OP_COL_MUL,
        OP_FORCE_MUL,
        OP_ACC,
        OP_LO_MUL,
        OP_HI_MUL,
        OP_VEL_UPD,
        OP_POS_UPD
    } dp_op_t;

    typedef struct packed {
        dp_op_t              op;
        logic [AXIS_W-1:0]   axis;
        logic                load_quat;
        logic                load_thrust;
        logic                load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic started;
    } dp_status_t;

endpackage

### rtl/core/tadr_datapath.sv
module tadr_datapath #(
    parameter int STATE_WIDTH    = tadr_pkg::STATE_WIDTH_DEF,
    parameter int QUAT_FRAC_BITS = tadr_pkg::QUAT_FRAC_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  tadr_pkg::dp_cmd_t                      cmd,
    output tadr_pkg::dp_status_t                   status,
    input  logic signed [tadr_pkg::QUAT_W-1:0]     quat_x,
    input  logic signed [tadr_pkg::QUAT_W-1:0]     quat_y,
    input  logic signed [tadr_pkg::QUAT_W-1:0]     quat_z,
    input  logic signed [tadr_pkg::QUAT_W-1:0]     quat_w,
    input  logic [tadr_pkg::THRUST_W-1:0]          thrust,
    input  logic                                   cfg_wen,
    input  logic [tadr_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [tadr_pkg::CFG_W-1:0]             cfg_wdata,
    output logic [tadr_pkg::M_DATA_W-1:0]          out_data
);

    localparam int SW   = STATE_WIDTH;
    localparam int QF   = QUAT_FRAC_BITS;
    localparam int MA_W = 33;
    localparam int MB_W = 25;
    localparam int P_W  = MA_W + MB_W;
    localparam int QP_W = 32;
    localparam int QW   = ((2 * QF > 32) ? 2 * QF : 32) + 3;
    localparam int EW   = ((SW > 40) ? SW : 40) + 2;
    localparam int FS   = QF + 8;
    localparam int CW   = tadr_pkg::COL_W;
    localparam logic signed [CW-1:0] COL_ONE =
        (QF < CW - 1) ? CW'(1 << QF) : {1'b0, {(CW - 1){1'b1}}};
    localparam logic signed [QW-1:0] Q_ONE = QW'(1) << (2 * QF);

    logic [tadr_pkg::GRAV_W-1:0]    grav_reg;
    logic [tadr_pkg::INVM_W-1:0]    inv_mass_reg;
    logic [tadr_pkg::DT_W-1:0]      dt_reg;
    logic signed [CW-1:0]           col_reg [tadr_pkg::AXES];
    logic [tadr_pkg::THRUST_W-1:0]  thrust_reg;
    logic signed [SW-1:0]           vel_reg [tadr_pkg::AXES];
    logic signed [SW-1:0]           pos_reg [tadr_pkg::AXES];
    logic                           ori_seen_reg;
    logic                           thr_seen_reg;
    logic signed [tadr_pkg::QUAT_W-1:0] qx_reg, qy_reg, qz_reg, qw_reg;
    logic signed [P_W-1:0]          prod_reg;
    logic signed [QP_W-1:0]         first_reg;
    logic [SW-1:0]                  mag_reg;
    logic                           neg_reg;
    logic [24:0]                    frac_reg;
    logic [tadr_pkg::M_DATA_W-1:0]  out_reg;

    logic signed [MA_W-1:0] mul_a;
    logic signed [MB_W-1:0] mul_b;
    logic signed [P_W-1:0]  mul_p;
    logic [SW+23:0]         mag_wide;
    logic [23:0]            mag_lo;
    logic [23:0]            mag_hi;

    logic signed [QW-1:0]   q_sum, q_diff, c_val;
    logic [QW-1:0]          c_mag, c_rnd;
    logic signed [QW-1:0]   c_signed;
    logic signed [CW-1:0]   col_next;

    logic [P_W-1:0]         f_mag, f_rnd;
    logic signed [EW-1:0]   f_signed;
    logic signed [EW-1:0]   acc_wide;
    logic signed [SW-1:0]   acc_next;

    logic [48:0]            lo_sum;
    logic [48:0]            step_mag;
    logic signed [SW:0]     step_abs;
    logic signed [EW-1:0]   step_val;
    logic signed [SW-1:0]   upd_base;
    logic signed [SW-1:0]   upd_next;

    logic [tadr_pkg::M_DATA_W-1:0] out_next;

    function automatic logic signed [SW-1:0] sat_state(input logic signed [EW-1:0] v);
        logic signed [EW-1:0] hi_lim;
        logic signed [EW-1:0] lo_lim;
        hi_lim = {{(EW - SW + 1){1'b0}}, {(SW - 1){1'b1}}};
        lo_lim = ~hi_lim;
        if (v > hi_lim) begin
            sat_state = hi_lim[SW-1:0];
        end else if (v < lo_lim) begin
            sat_state = lo_lim[SW-1:0];
        end else begin
            sat_state = v[SW-1:0];
        end
    endfunction

    function automatic logic [tadr_pkg::OUT_W-1:0] sat_out(input logic signed [EW-1:0] v);
        logic signed [EW-1:0] hi_lim;
        logic signed [EW-1:0] lo_lim;
        hi_lim = {{(EW - tadr_pkg::OUT_W + 1){1'b0}}, {(tadr_pkg::OUT_W - 1){1'b1}}};
        lo_lim = ~hi_lim;
        if (v > hi_lim) begin
            sat_out = hi_lim[tadr_pkg::OUT_W-1:0];
        end else if (v < lo_lim) begin
            sat_out = lo_lim[tadr_pkg::OUT_W-1:0];
        end else begin
            sat_out = v[tadr_pkg::OUT_W-1:0];
        end
    endfunction

    // split the stored magnitude for the two-pass step product
    assign mag_wide = {24'd0, mag_reg};
    assign mag_lo   = mag_wide[23:0];
    assign mag_hi   = mag_wide[47:24];

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            tadr_pkg::OP_QMUL, tadr_pkg::OP_QMUL2: begin
                case ({cmd.axis, cmd.op == tadr_pkg::OP_QMUL2})
                    3'b000: begin mul_a = MA_W'(qx_reg); mul_b = MB_W'(qz_reg); end
                    3'b001: begin mul_a = MA_W'(qw_reg); mul_b = MB_W'(qy_reg); end
                    3'b010: begin mul_a = MA_W'(qy_reg); mul_b = MB_W'(qz_reg); end
                    3'b011: begin mul_a = MA_W'(qw_reg); mul_b = MB_W'(qx_reg); end
                    3'b100: begin mul_a = MA_W'(qx_reg); mul_b = MB_W'(qx_reg); end
                    3'b101: begin mul_a = MA_W'(qy_reg); mul_b = MB_W'(qy_reg); end
                    default: begin mul_a = '0; mul_b = '0; end
                endcase
            end
            tadr_pkg::OP_COL_MUL: begin
                mul_a = MA_W'(col_reg[cmd.axis]);
                mul_b = {9'd0, thrust_reg};
            end
            tadr_pkg::OP_FORCE_MUL: begin
                mul_a = prod_reg[MA_W-1:0];
                mul_b = {1'b0, inv_mass_reg};
            end
            tadr_pkg::OP_LO_MUL: begin
                mul_a = {9'd0, mag_lo};
                mul_b = {1'b0, dt_reg};
            end
            tadr_pkg::OP_HI_MUL: begin
                mul_a = {9'd0, mag_hi};
                mul_b = {1'b0, dt_reg};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = P_W'(mul_a) * P_W'(mul_b);

    // column entry from the two quaternion products
    always_comb begin
        q_sum  = QW'(first_reg) + QW'(signed'(prod_reg[QP_W-1:0]));
        q_diff = QW'(first_reg) - QW'(signed'(prod_reg[QP_W-1:0]));
        case (cmd.axis)
            2'd0:    c_val = -(q_sum <<< 1);
            2'd1:    c_val = q_diff <<< 1;
            default: c_val = Q_ONE - (q_sum <<< 1);
        endcase
        c_mag    = c_val[QW-1] ? QW'(-c_val) : QW'(c_val);
        c_rnd    = (c_mag + (QW'(1) << (QF - 1))) >> QF;
        c_signed = c_val[QW-1] ? -signed'(c_rnd) : signed'(c_rnd);
        if (c_signed > QW'(signed'({1'b0, {(CW - 1){1'b1}}}))) begin
            col_next = {1'b0, {(CW - 1){1'b1}}};
        end else if (c_signed < QW'(signed'({1'b1, {(CW - 1){1'b0}}}))) begin
            col_next = {1'b1, {(CW - 1){1'b0}}};
        end else begin
            col_next = c_signed[CW-1:0];
        end
    end

    // acceleration: gravity on the down axis less rounded thrust force
    always_comb begin
        f_mag    = prod_reg[P_W-1] ? P_W'(-prod_reg) : P_W'(prod_reg);
        f_rnd    = (f_mag + (P_W'(1) << (FS - 1))) >> FS;
        f_signed = prod_reg[P_W-1] ? -signed'(EW'(f_rnd)) : signed'(EW'(f_rnd));
        acc_wide = ((cmd.axis == 2'd2) ? signed'(EW'(grav_reg)) : '0) - f_signed;
        acc_next = sat_state(acc_wide);
    end

    // signed step from the two partial products, then the saturated sum
    always_comb begin
        lo_sum   = 49'(prod_reg[47:0]) + 49'(1 << 23);
        step_mag = 49'(prod_reg[47:0]) + 49'(frac_reg);
        step_abs = signed'(step_mag[SW:0]);
        step_val = neg_reg ? -EW'(step_abs) : EW'(step_abs);
        upd_base = (cmd.op == tadr_pkg::OP_VEL_UPD) ? vel_reg[cmd.axis] : pos_reg[cmd.axis];
        upd_next = sat_state(EW'(upd_base) + step_val);
    end

    always_comb begin
        out_next = {sat_out(-EW'(vel_reg[2])),
                    sat_out(-EW'(vel_reg[1])),
                    sat_out(EW'(vel_reg[0])),
                    sat_out(-EW'(pos_reg[2])),
                    sat_out(-EW'(pos_reg[1])),
                    sat_out(EW'(pos_reg[0]))};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grav_reg     <= tadr_pkg::GRAVITY_RESET;
            inv_mass_reg <= tadr_pkg::INVERSE_MASS_RESET;
            dt_reg       <= tadr_pkg::TIME_STEP_RESET;
            col_reg[0]   <= '0;
            col_reg[1]   <= '0;
            col_reg[2]   <= COL_ONE;
            thrust_reg   <= '0;
            for (int i = 0; i < tadr_pkg::AXES; i++) begin
                vel_reg[i] <= '0;
            end
            pos_reg[0]   <= '0;
            pos_reg[1]   <= '0;
            pos_reg[2]   <= sat_state(EW'(tadr_pkg::INITIAL_DOWN_RESET));
            ori_seen_reg <= 1'b0;
            thr_seen_reg <= 1'b0;
        end else begin
            if (cfg_wen) begin
                unique case (cfg_index)
                    tadr_pkg::CFG_GRAVITY:      grav_reg <= cfg_wdata[tadr_pkg::GRAV_W-1:0];
                    tadr_pkg::CFG_INVERSE_MASS: inv_mass_reg <= cfg_wdata[tadr_pkg::INVM_W-1:0];
                    tadr_pkg::CFG_TIME_STEP:    dt_reg <= cfg_wdata[tadr_pkg::DT_W-1:0];
                    tadr_pkg::CFG_INITIAL_DOWN: begin
                        if (!(ori_seen_reg && thr_seen_reg)) begin
                            pos_reg[2] <= sat_state(EW'(signed'(cfg_wdata)));
                        end
                    end
                    default: ;
                endcase
            end
            if (cmd.load_quat) begin
                ori_seen_reg <= 1'b1;
            end
            if (cmd.load_thrust) begin
                thrust_reg   <= thrust;
                thr_seen_reg <= 1'b1;
            end
            case (cmd.op)
                tadr_pkg::OP_COL_SET: col_reg[cmd.axis] <= col_next;
                tadr_pkg::OP_VEL_UPD: vel_reg[cmd.axis] <= upd_next;
                tadr_pkg::OP_POS_UPD: pos_reg[cmd.axis] <= upd_next;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_quat) begin
            qx_reg <= quat_x;
            qy_reg <= quat_y;
            qz_reg <= quat_z;
            qw_reg <= quat_w;
        end
        if (cmd.op == tadr_pkg::OP_QMUL2) begin
            first_reg <= prod_reg[QP_W-1:0];
        end
        if (cmd.op == tadr_pkg::OP_HI_MUL) begin
            frac_reg <= lo_sum[48:24];
        end
        case (cmd.op)
            tadr_pkg::OP_QMUL, tadr_pkg::OP_QMUL2, tadr_pkg::OP_COL_MUL,
            tadr_pkg::OP_FORCE_MUL, tadr_pkg::OP_LO_MUL, tadr_pkg::OP_HI_MUL: begin
                prod_reg <= mul_p;
            end
            tadr_pkg::OP_ACC: begin
                mag_reg <= acc_next[SW-1] ? SW'(-acc_next) : SW'(acc_next);
                neg_reg <= acc_next[SW-1];
            end
            tadr_pkg::OP_VEL_UPD: begin
                mag_reg <= upd_next[SW-1] ? SW'(-upd_next) : SW'(upd_next);
                neg_reg <= upd_next[SW-1];
            end
            default: ;
        endcase
        if (cmd.load_out) begin
            out_reg <= out_next;
        end
    end

    assign status.started = ori_seen_reg && thr_seen_reg;
    assign out_data       = out_reg;

endmodule

### rtl/core/tadr_ctrl.sv
module tadr_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [tadr_pkg::CMD_W-1:0]    s_command,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    input  tadr_pkg::dp_status_t          status,
    output tadr_pkg::dp_cmd_t             cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ORIENT,
        S_TICK,
        S_OUT
    } state_t;

    state_t                            state_reg;
    logic [tadr_pkg::STEP_W-1:0]       step_reg;
    logic [tadr_pkg::AXIS_W-1:0]       axis_reg;
    logic                              out_valid_reg;
    logic                              accept;
    logic                              out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;

    always_comb begin
        cmd             = '0;
        cmd.op          = tadr_pkg::OP_NONE;
        cmd.axis        = axis_reg;
        cmd.load_quat   = accept && (s_command == tadr_pkg::CMD_ORIENT);
        cmd.load_thrust = accept && (s_command == tadr_pkg::CMD_THRUST);
        cmd.load_out    = (state_reg == S_OUT) && out_free;
        unique case (state_reg)
            S_ORIENT: begin
                unique case (step_reg)
                    4'd0:    cmd.op = tadr_pkg::OP_QMUL;
                    4'd1:    cmd.op = tadr_pkg::OP_QMUL2;
                    default: cmd.op = tadr_pkg::OP_COL_SET;
                endcase
            end
            S_TICK: begin
                unique case (step_reg)
                    4'd0:       cmd.op = tadr_pkg::OP_COL_MUL;
                    4'd1:       cmd.op = tadr_pkg::OP_FORCE_MUL;
                    4'd2:       cmd.op = tadr_pkg::OP_ACC;
                    4'd3, 4'd6: cmd.op = tadr_pkg::OP_LO_MUL;
                    4'd4, 4'd7: cmd.op = tadr_pkg::OP_HI_MUL;
                    4'd5:       cmd.op = tadr_pkg::OP_VEL_UPD;
                    default:    cmd.op = tadr_pkg::OP_POS_UPD;
                endcase
            end
            default: cmd.op = tadr_pkg::OP_NONE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            axis_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (state_reg == S_OUT && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (out_valid_reg && m_tready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    step_reg <= '0;
                    axis_reg <= '0;
                    if (accept && s_command == tadr_pkg::CMD_ORIENT) begin
                        state_reg <= S_ORIENT;
                    end else if (accept && s_command == tadr_pkg::CMD_TICK
                                 && status.started) begin
                        state_reg <= S_TICK;
                    end
                end
                S_ORIENT: begin
                    if (step_reg == tadr_pkg::STEP_W'(tadr_pkg::ORIENT_STEPS - 1)) begin
                        step_reg <= '0;
                        if (axis_reg == tadr_pkg::AXIS_W'(tadr_pkg::AXES - 1)) begin
                            state_reg <= S_IDLE;
                        end else begin
                            axis_reg <= axis_reg + 1'b1;
                        end
                    end else begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                S_TICK: begin
                    if (step_reg == tadr_pkg::STEP_W'(tadr_pkg::TICK_STEPS - 1)) begin
                        step_reg <= '0;
                        if (axis_reg == tadr_pkg::AXIS_W'(tadr_pkg::AXES - 1)) begin
                            state_reg <= S_OUT;
                        end else begin
                            axis_reg <= axis_reg + 1'b1;
                        end
                    end else begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

### rtl/core/thrust_attitude_dead_reckoning.sv
// Dead reckoning of position and velocity from collective thrust and attitude.
// Input channel (s_): each item carries a command in s_tuser. An orientation
// item loads the quaternion and builds the down column, holding s_tready low
// while it runs. A thrust item is stored in the cycle it is accepted. A tick,
// once an orientation and a thrust have both arrived, runs the force, velocity
// and position update for the three axes on one shared 33x25 multiplier,
// one axis after another, and places one result item in the output register.
// s_tready returns high in the same cycle that m_tvalid rises. A tick before
// start and command 3 give no result and leave s_tready high.
// Result channel (m_): position and velocity in ENU, Q16.16. While the
// receiver stalls, the result holds in the output register; items that give
// no result are still accepted, and a further tick waits at its end until the
// output register is free.
// Configuration: cfg_wen writes cfg_wdata to register cfg_index at the clock
// edge (initial down only before start); write only while the block is idle.
// Reset (aresetn low, synchronous) restores registers, column, velocity and
// position to their defaults and clears both start flags.
module thrust_attitude_dead_reckoning #(
    parameter int STATE_WIDTH    = tadr_pkg::STATE_WIDTH_DEF,
    parameter int QUAT_FRAC_BITS = tadr_pkg::QUAT_FRAC_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // quat_x, quat_y, quat_z, quat_w, thrust
    input  logic [tadr_pkg::S_DATA_W-1:0]      s_tdata,
    // command
    input  logic [tadr_pkg::CMD_W-1:0]         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // pos_east, pos_north, pos_up, vel_east, vel_north, vel_up
    output logic [tadr_pkg::M_DATA_W-1:0]      m_tdata,
    input  logic                               cfg_wen,
    input  logic [tadr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tadr_pkg::CFG_W-1:0]         cfg_wdata
);

    tadr_pkg::dp_cmd_t    cmd;
    tadr_pkg::dp_status_t status;

    tadr_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_command (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    tadr_datapath #(
        .STATE_WIDTH    (STATE_WIDTH),
        .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .quat_x    (s_tdata[15:0]),
        .quat_y    (s_tdata[31:16]),
        .quat_z    (s_tdata[47:32]),
        .quat_w    (s_tdata[63:48]),
        .thrust    (s_tdata[79:64]),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .out_data  (m_tdata)
    );

endmodule
